// ===== sv/sstpr_pkg.sv =====
`default_nettype none
package sstpr_pkg;

  // operation codes
  localparam logic [1:0] FN_SWAP_OUT = 2'd0;
  localparam logic [1:0] FN_FAULT    = 2'd1;
  localparam logic [1:0] FN_FREE     = 2'd2;
  localparam logic [1:0] FN_NONE     = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SLOT   = 2'd1;
  localparam logic [1:0] ST_BAD_BLOCK = 2'd2;

  // slot i lives at disk block BLOCK_BASE + (i << STRIDE_SHIFT)
  localparam int          STRIDE_SHIFT = 3;
  localparam logic [19:0] BLOCK_BASE   = 20'd2;

  // slot numbering and cell geometry
  localparam int SIDX_W     = 12;
  localparam int CELL_W     = 5;
  localparam int CELL_SLOTS = 1 << CELL_W;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] pte_value;
    logic [19:0] new_frame;
    logic [7:0]  slot_index;
  } sstpr_in_t;

  typedef struct packed {
    logic [31:0] new_pte;
    logic [10:0] disk_block;
    logic [7:0]  slot_used;
    logic [19:0] freed_frame;
    logic [1:0]  status;
  } sstpr_out_t;

  // word handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic [1:0]        func;
    logic              bad;    // fault or free names no slot
    logic [31:0]       pte;
    logic [19:0]       frame;
    logic [SIDX_W-1:0] slot;   // target slot, or the slot allocated
    logic              hit;    // swap out has found its slot
    logic [11:0]       flags;  // flags read back on fault
  } sstpr_word_t;

endpackage
`default_nettype wire

// ===== sv/sstpr_cell.sv =====
`default_nettype none
module sstpr_cell #(
  parameter int CELL_ID = 0,
  parameter int LIVE    = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire sstpr_pkg::sstpr_word_t w_in,
  output sstpr_pkg::sstpr_word_t    w_out
);
  import sstpr_pkg::*;

  localparam logic [CELL_SLOTS-1:0] LIVE_MASK =
    CELL_SLOTS'((64'd1 << LIVE) - 64'd1);
  localparam logic [SIDX_W-CELL_W-1:0] MY_ID = (SIDX_W-CELL_W)'(CELL_ID);

  logic [CELL_SLOTS-1:0] free;
  logic [11:0]           flags [CELL_SLOTS];

  logic [CELL_SLOTS-1:0] lowbit;
  logic [CELL_W-1:0]     loc;
  logic                  any_free;
  logic                  mine;
  logic [CELL_W-1:0]     sub;
  logic                  do_alloc;
  logic                  do_release;
  sstpr_word_t           w_next;

  // lowest free slot: isolate the lowest set bit, then encode it
  always_comb begin
    lowbit   = free & ((~free) + {{(CELL_SLOTS-1){1'b0}}, 1'b1});
    any_free = |free;
    loc      = '0;
    for (int i = 0; i < CELL_SLOTS; i++) begin
      loc = loc | (lowbit[i] ? CELL_W'(i) : '0);
    end
  end

  always_comb begin
    sub        = w_in.slot[CELL_W-1:0];
    mine       = (w_in.slot[SIDX_W-1:CELL_W] == MY_ID) && !w_in.bad;
    do_alloc   = w_in.vld && (w_in.func == FN_SWAP_OUT) && !w_in.hit && any_free;
    do_release = w_in.vld && mine && ((w_in.func == FN_FAULT) || (w_in.func == FN_FREE));
    w_next     = w_in;
    if (do_alloc) begin
      w_next.hit  = 1'b1;
      w_next.slot = {MY_ID, loc};
    end
    if (w_in.vld && mine && (w_in.func == FN_FAULT)) begin
      w_next.flags = flags[sub];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free      <= LIVE_MASK;
      w_out.vld <= 1'b0;
      for (int i = 0; i < CELL_SLOTS; i++) begin
        flags[i] <= '0;
      end
    end else if (en) begin
      w_out <= w_next;
      if (do_alloc) begin
        free[loc]  <= 1'b0;
        flags[loc] <= w_in.pte[11:0];
      end else if (do_release) begin
        free[sub] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/swap_slot_table_pte_rewrite.sv =====
`default_nettype none
// Swap slot table. The slots sit in a row of cells of 32 slots each
// (ceil(SLOT_COUNT/32) cells); every word walks the row one cell per
// cycle while the output is not stalled, the first cell with a free
// slot serves a swap out and the owning cell serves a fault or free.
// One word can be taken in every cycle while the output is not
// stalled, since each cell sees the words in order. The swap mark
// register is applied at the output stage, and writes to it are always
// taken (cfg_ready is tied high).
module swap_slot_table_pte_rewrite #(
  parameter int SLOT_COUNT = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire sstpr_pkg::sstpr_in_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sstpr_pkg::sstpr_out_t     out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [11:0]          cfg_data
);
  import sstpr_pkg::*;

  localparam int NCELL = (SLOT_COUNT + CELL_SLOTS - 1) / CELL_SLOTS;

  logic        en;
  logic [11:0] mask;
  sstpr_word_t w [NCELL+1];

  logic [19:0] blk;
  logic [19:0] off;
  logic        fault_ok;
  logic        free_ok;
  sstpr_out_t  res;
  sstpr_word_t last;

  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // entry decode: locate the slot named by a fault or free
  always_comb begin
    blk      = in_data.pte_value[31:12];
    off      = blk - BLOCK_BASE;
    fault_ok = (blk >= BLOCK_BASE) && (off[STRIDE_SHIFT-1:0] == '0) &&
               ({3'b000, off[19:STRIDE_SHIFT]} < 20'(SLOT_COUNT));
    free_ok  = {5'b00000, in_data.slot_index} < 13'(SLOT_COUNT);
    w[0]       = '0;
    w[0].vld   = in_valid;
    w[0].func  = in_data.func;
    w[0].pte   = in_data.pte_value;
    w[0].frame = in_data.new_frame;
    if (in_data.func == FN_FAULT) begin
      w[0].slot = off[STRIDE_SHIFT+SIDX_W-1:STRIDE_SHIFT];
      w[0].bad  = !fault_ok;
    end else if (in_data.func == FN_FREE) begin
      w[0].slot = SIDX_W'(in_data.slot_index);
      w[0].bad  = !free_ok;
    end
  end

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    localparam int REST = SLOT_COUNT - c * CELL_SLOTS;
    localparam int LIVE = (REST >= CELL_SLOTS) ? CELL_SLOTS : REST;
    sstpr_cell #(
      .CELL_ID(c),
      .LIVE   (LIVE)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .w_in (w[c]),
      .w_out(w[c+1])
    );
  end

  // result formatting
  always_comb begin
    last = w[NCELL];
    res  = '0;
    if (last.func == FN_SWAP_OUT) begin
      if (last.hit) begin
        res.new_pte     = {5'b00000, last.slot, 3'd2, last.pte[11:1], 1'b0} |
                          {20'd0, mask};
        res.disk_block  = {last.slot[7:0], 3'd2};
        res.slot_used   = last.slot[7:0];
        res.freed_frame = last.pte[31:12];
      end else begin
        res.status  = ST_NO_SLOT;
        res.new_pte = last.pte;
      end
    end else if (last.func == FN_FAULT) begin
      if (last.bad) begin
        res.status  = ST_BAD_BLOCK;
        res.new_pte = last.pte;
      end else begin
        res.new_pte    = {last.frame, last.flags | 12'd1} & ~{20'd0, mask};
        res.disk_block = last.pte[22:12];
        res.slot_used  = last.slot[7:0];
      end
    end else if (last.func == FN_FREE) begin
      if (last.bad) begin
        res.status = ST_BAD_BLOCK;
      end else begin
        res.disk_block = {last.slot[7:0], 3'd2};
        res.slot_used  = last.slot[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      mask      <= 12'd512;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mask <= cfg_data;
      end
      if (en) begin
        out_valid <= last.vld;
        out_data  <= res;
      end
    end
  end

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output free");

  a_no_slot_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status == ST_NO_SLOT)) |->
      ((out_data.slot_used == '0) && (out_data.disk_block == '0) &&
       (out_data.freed_frame == '0)))
    else $error("no-slot word carries slot fields");

  a_freed_frame_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.freed_frame != '0)) |-> (out_data.status == ST_OK))
    else $error("freed frame on failed operation");

  a_mask_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (mask == $past(cfg_data)))
    else $error("swap mark write lost");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import sstpr_pkg::*;

  localparam int NUM_SLOTS = 256;

  // Shadow copy of the slot table; predicts one result word per request word.
  class slot_table_shadow;
    bit          slot_free[NUM_SLOTS];
    logic [11:0] saved_flags[NUM_SLOTS];
    logic [11:0] swap_mark;
    sstpr_out_t  due_results[$];
    int          errors;

    function new();
      foreach (slot_free[i]) begin
        slot_free[i] = 1'b1;
        saved_flags[i] = '0;
      end
      swap_mark = 12'd512;
      errors = 0;
    endfunction

    function logic [19:0] slot_block(int s);
      return BLOCK_BASE + (20'(s) << STRIDE_SHIFT);
    endfunction

    function void take_request(sstpr_in_t req);
      sstpr_out_t  r;
      logic [19:0] blk;
      int          s;
      int          b;
      r = '0;
      case (req.func)
        FN_SWAP_OUT: begin
          s = 0;
          while (s < NUM_SLOTS && !slot_free[s]) s++;
          if (s == NUM_SLOTS) begin
            r.status = ST_NO_SLOT;
            r.new_pte = req.pte_value;
          end else begin
            blk = slot_block(s);
            slot_free[s] = 1'b0;
            saved_flags[s] = req.pte_value[11:0];
            r.freed_frame = req.pte_value[31:12];
            r.new_pte = {blk, req.pte_value[11:1], 1'b0} | {20'd0, swap_mark};
            r.disk_block = blk[10:0];
            r.slot_used = 8'(s);
          end
        end
        FN_FAULT: begin
          blk = req.pte_value[31:12];
          b = int'(blk);
          s = (b >= int'(BLOCK_BASE)) ? (b - int'(BLOCK_BASE)) >> STRIDE_SHIFT : 0;
          if (b < int'(BLOCK_BASE) || ((b - int'(BLOCK_BASE)) % (1 << STRIDE_SHIFT)) != 0 ||
              s >= NUM_SLOTS) begin
            r.status = ST_BAD_BLOCK;
            r.new_pte = req.pte_value;
          end else begin
            r.new_pte = ({req.new_frame, saved_flags[s]} | 32'd1) & ~{20'd0, swap_mark};
            slot_free[s] = 1'b1;
            r.disk_block = blk[10:0];
            r.slot_used = 8'(s);
          end
        end
        FN_FREE: begin
          s = int'(req.slot_index);
          if (s >= NUM_SLOTS) begin
            r.status = ST_BAD_BLOCK;
          end else begin
            blk = slot_block(s);
            slot_free[s] = 1'b1;
            r.disk_block = blk[10:0];
            r.slot_used = req.slot_index;
          end
        end
        default: ;
      endcase
      due_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(sstpr_out_t got);
      sstpr_out_t want;
      if (due_results.size() == 0) begin
        $error("result word with nothing outstanding: %0h", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("new_pte", want.new_pte, got.new_pte);
      compare_field("disk_block", 32'(want.disk_block), 32'(got.disk_block));
      compare_field("slot_used", 32'(want.slot_used), 32'(got.slot_used));
      compare_field("freed_frame", 32'(want.freed_frame), 32'(got.freed_frame));
      compare_field("status", 32'(want.status), 32'(got.status));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  sstpr_in_t   in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  sstpr_out_t  out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_data = '0;

  slot_table_shadow shadow;
  int in_gap_max = 11;
  int out_gap_max = 11;
  int long_hold = 0;
  int stall_left = 0;

  swap_slot_table_pte_rewrite #(
    .SLOT_COUNT(NUM_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  initial begin
    #2_000_000;
    $display("FAIL swap_slot_table_pte_rewrite");
    $finish;
  end

  // Sample handshakes with pre-edge values; result checked before the new
  // request is noted. Receiver stall is counted here as well.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        shadow.check_result(out_data);
        stall_left = $urandom_range(0, out_gap_max);
      end
      if (in_valid && !in_stall) shadow.take_request(in_data);
      if (long_hold > 0) begin
        stall_left = long_hold;
        long_hold = 0;
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic send_word(input sstpr_in_t w);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic issue(input logic [1:0] f, input logic [31:0] pte, input logic [19:0] frame,
                       input logic [7:0] sidx);
    sstpr_in_t w;
    w = '{func: f, pte_value: pte, new_frame: frame, slot_index: sidx};
    send_word(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    // let the word taken at this edge reach the scoreboard first
    @(negedge clk);
    while (shadow.due_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_swap_mark(input logic [11:0] m);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow.swap_mark = m;
  endtask

  function automatic int pick_busy_slot();
    int s;
    for (int k = 0; k < 16; k++) begin
      s = $urandom_range(0, NUM_SLOTS - 1);
      if (!shadow.slot_free[s]) return s;
    end
    return $urandom_range(0, NUM_SLOTS - 1);
  endfunction

  function automatic sstpr_in_t make_word(int w_swap, int w_fault, int w_free);
    sstpr_in_t w;
    int        roll;
    w.func = FN_NONE;
    w.pte_value = $urandom();
    w.new_frame = 20'($urandom());
    w.slot_index = 8'($urandom());
    roll = $urandom_range(0, 99);
    if (roll < w_swap) begin
      w.func = FN_SWAP_OUT;
    end else if (roll < w_swap + w_fault) begin
      w.func = FN_FAULT;
      case ($urandom_range(0, 9))
        0: ; // raw block, almost never a slot
        1: w.pte_value[31:12] = shadow.slot_block(pick_busy_slot()) + 20'($urandom_range(1, 7));
        2: w.pte_value[31:12] = shadow.slot_block(NUM_SLOTS + $urandom_range(0, 300));
        3: w.pte_value[31:12] = shadow.slot_block($urandom_range(0, NUM_SLOTS - 1));
        default: w.pte_value[31:12] = shadow.slot_block(pick_busy_slot());
      endcase
    end else if (roll < w_swap + w_fault + w_free) begin
      w.func = FN_FREE;
      if ($urandom_range(0, 2) != 0) w.slot_index = 8'(pick_busy_slot());
    end
    return w;
  endfunction

  task automatic run_random(input int n, input int w_swap, input int w_fault, input int w_free);
    repeat (n) send_word(make_word(w_swap, w_fault, w_free));
  endtask

  initial begin
    int drain;
    shadow = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, swap mark still at its reset value
    issue(FN_NONE, '1, '1, '1);
    issue(FN_NONE, '0, '0, '0);
    issue(FN_SWAP_OUT, 32'hFFFF_FFFF, '0, '0);
    issue(FN_SWAP_OUT, 32'h0000_0000, '1, '1);
    issue(FN_SWAP_OUT, 32'h1234_5ABC, '0, '0);
    issue(FN_FAULT, 32'h0000_2FFF, 20'hFFFFF, '0);
    issue(FN_FAULT, 32'h0000_2000, 20'h00000, '0);   // slot already free
    issue(FN_FAULT, 32'h0000_A555, 20'hABCDE, '0);
    issue(FN_FAULT, 32'h0000_0FFF, '1, '0);          // block below base
    issue(FN_FAULT, 32'h0000_1000, '1, '0);
    issue(FN_FAULT, 32'h0000_3000, '1, '0);          // off the stride
    issue(FN_FAULT, 32'h0080_2000, '1, '0);          // one past the last slot
    issue(FN_FAULT, 32'hFFFF_F000, '1, '0);
    issue(FN_FAULT, 32'h007F_A123, 20'h12345, '0);   // last slot, never used
    issue(FN_FREE, '0, '0, 8'd2);
    issue(FN_FREE, '1, '1, 8'd255);
    issue(FN_FREE, '0, '0, 8'd0);
    issue(FN_SWAP_OUT, 32'h0000_0001, '0, '0);
    issue(FN_SWAP_OUT, 32'hFFFF_F200, '0, '0);
    issue(FN_FAULT, 32'h0001_2000, '1, '0);          // freed slot keeps its flags
    issue(FN_NONE, 32'hA5A5_5A5A, 20'h5A5A5, 8'hA5);

    write_swap_mark(12'h000);
    run_random(250, 40, 35, 15);

    // fill the table until swap outs find no slot
    write_swap_mark(12'hFFF);
    in_gap_max = 0;
    out_gap_max = 0;
    repeat (260) send_word(make_word(100, 0, 0));
    in_gap_max = 11;
    out_gap_max = 11;
    run_random(150, 55, 25, 10);

    // long receiver hold-off while the sender keeps pushing
    write_swap_mark(12'h001);
    long_hold = 300;
    in_gap_max = 0;
    @(posedge clk);
    run_random(40, 40, 35, 15);
    in_gap_max = 11;
    run_random(300, 30, 50, 15);

    write_swap_mark(12'($urandom_range(2, 4094)));
    in_gap_max = 0;
    out_gap_max = 0;
    run_random(300, 40, 35, 15);
    in_gap_max = 11;
    out_gap_max = 11;

    write_swap_mark(12'h200);
    run_random(400, 40, 35, 15);

    in_valid <= 1'b0;
    @(negedge clk);
    drain = 0;
    while (shadow.due_results.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (shadow.due_results.size() != 0) begin
      $error("%0d result words never came", shadow.due_results.size());
      shadow.errors++;
    end
    if (shadow.errors == 0) begin
      $display("PASS swap_slot_table_pte_rewrite");
    end else begin
      $display("FAIL swap_slot_table_pte_rewrite");
    end
    $finish;
  end

endmodule
